>>> rtl/ahcfp_pkg.sv
// Shared types, constants and the hex digit decoder for the command frame parser.
`default_nettype none

package ahcfp_pkg;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] CASE_BIT     = 8'h20;
   localparam logic [7:0] COUNT_MAX    = 8'd255;
   // Line length counts the newline, so these are compared against count + 1.
   localparam logic [7:0] FULL_LEN     = 8'd12;
   localparam logic [7:0] HELP_MAX_LEN = 8'd2;

   // Character positions of the hex digits within a line.
   localparam logic [7:0] POS_CMD_HI = 8'd1;
   localparam logic [7:0] POS_CMD_LO = 8'd2;
   localparam logic [7:0] POS_PAR_HI = 8'd4;
   localparam logic [7:0] POS_PAR_LO = 8'd5;
   localparam logic [7:0] POS_VAL_HI = 8'd7;
   localparam logic [7:0] POS_VAL_LO = 8'd8;
   localparam logic [7:0] POS_CHK_HI = 8'd10;
   localparam logic [7:0] POS_CHK_LO = 8'd11;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_PARITY_ERR = 2'd1,
      STATUS_INCOMPLETE = 2'd2,
      STATUS_HELP       = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] param_byte;
      logic [7:0] value_byte;
      logic [7:0] parity_rx;
      status_type status;
   } frame_type;

   // Anything that is not 0-9, a-f or A-F decodes as zero.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] lc;
      lc = c | CASE_BIT;
      if (c inside {[8'h30:8'h39]}) begin
         return c[3:0];
      end else if (lc inside {[8'h61:8'h66]}) begin
         return 4'(lc[3:0] + 4'd9);
      end else begin
         return 4'd0;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/ahcfp_line_acc.sv
// Per-line state: character count, byte assembly by position and end-of-line judgment.
`default_nettype none

module ahcfp_line_acc
   import ahcfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       char_valid,
   input  wire logic [7:0] rx_char,
   output logic            frame_done,
   output frame_type       frame
);

   logic [7:0] count_ff, count_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] par_ff, par_in;
   logic [7:0] val_ff, val_in;
   logic [7:0] chk_ff, chk_in;
   logic [3:0] nib;
   logic       is_newline;

   assign is_newline = (rx_char == NEWLINE_CHAR);
   assign nib        = hex_nibble(rx_char);
   assign frame_done = char_valid && is_newline;

   // Judgment uses the state before the newline; fields report what was assembled.
   always_comb begin
      frame.command    = cmd_ff;
      frame.param_byte = par_ff;
      frame.value_byte = val_ff;
      frame.parity_rx  = chk_ff;
      if (count_ff < HELP_MAX_LEN) begin
         frame.status = STATUS_HELP;
      end else if (count_ff < 8'(FULL_LEN - 8'd1)) begin
         frame.status = STATUS_INCOMPLETE;
      end else if ((cmd_ff ^ par_ff ^ val_ff) == chk_ff) begin
         frame.status = STATUS_OK;
      end else begin
         frame.status = STATUS_PARITY_ERR;
      end
   end

   always_comb begin
      count_in = count_ff;
      cmd_in   = cmd_ff;
      par_in   = par_ff;
      val_in   = val_ff;
      chk_in   = chk_ff;
      if (char_valid) begin
         if (is_newline) begin
            count_in = 8'd0;
            cmd_in   = 8'd0;
            par_in   = 8'd0;
            val_in   = 8'd0;
            chk_in   = 8'd0;
         end else begin
            case (count_ff)
               POS_CMD_HI: cmd_in = {nib, cmd_ff[3:0]};
               POS_CMD_LO: cmd_in = {cmd_ff[7:4], nib};
               POS_PAR_HI: par_in = {nib, par_ff[3:0]};
               POS_PAR_LO: par_in = {par_ff[7:4], nib};
               POS_VAL_HI: val_in = {nib, val_ff[3:0]};
               POS_VAL_LO: val_in = {val_ff[7:4], nib};
               POS_CHK_HI: chk_in = {nib, chk_ff[3:0]};
               POS_CHK_LO: chk_in = {chk_ff[7:4], nib};
               default:    ;
            endcase
            if (count_ff != COUNT_MAX) begin
               count_in = 8'(count_ff + 8'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         cmd_ff   <= 8'd0;
         par_ff   <= 8'd0;
         val_ff   <= 8'd0;
         chk_ff   <= 8'd0;
      end else begin
         count_ff <= count_in;
         cmd_ff   <= cmd_in;
         par_ff   <= par_in;
         val_ff   <= val_in;
         chk_ff   <= chk_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ascii_hex_command_frame_parser.sv
// Top level of the ASCII hex command frame parser: input register, line logic, result register.
`default_nettype none

// Takes one received character per transaction and frames newline-ended lines of the form
// C hh P hh V hh Q hh. Hex pairs are picked by position (1-2 command, 4-5 parameter,
// 7-8 value, 10-11 parity), case-insensitive, with any other character decoding as 0.
// Each newline yields one result transaction carrying the four bytes and a status:
// accepted, parity error, incomplete line (3..11 characters) or help request (2 or fewer).
// Characters accept one per cycle while the input side is not stalled; a newline transaction passes
// through the input register, then the combinational line logic, then the result register.
// The input side stalls only while a result waits and the output side is stalled.

module ascii_hex_command_frame_parser
   import ahcfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_command,
   output logic [7:0]      rsp_param_byte,
   output logic [7:0]      rsp_value_byte,
   output logic [7:0]      rsp_parity_rx,
   output logic [1:0]      rsp_status
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       out_valid_ff, out_valid_in;
   frame_type  out_frame_ff;
   logic       advance;
   logic       req_accept;
   logic       frame_done;
   frame_type  frame;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   ahcfp_line_acc u_line_acc (
      .clock      (clock),
      .reset      (reset),
      .char_valid (in_valid_ff && advance),
      .rx_char    (in_char_ff),
      .frame_done (frame_done),
      .frame      (frame)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_rx_char;
      end
      if (advance && frame_done) begin
         out_frame_ff <= frame;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_command    = out_frame_ff.command;
   assign rsp_param_byte = out_frame_ff.param_byte;
   assign rsp_value_byte = out_frame_ff.value_byte;
   assign rsp_parity_rx  = out_frame_ff.parity_rx;
   assign rsp_status     = out_frame_ff.status;

endmodule

`default_nettype wire

>>> bench/tb_ascii_hex_command_frame_parser.sv
// Testbench for the ASCII hex command frame parser: drives characters, predicts and checks frames.
module tb_ascii_hex_command_frame_parser;
   import ahcfp_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 11;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_MAX   = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_char;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_command;
   logic [7:0] rsp_param_byte;
   logic [7:0] rsp_value_byte;
   logic [7:0] rsp_parity_rx;
   logic [1:0] rsp_status;

   // line state of the predictor
   logic [7:0] line_len = '0;
   logic [7:0] cmd_acc  = '0;
   logic [7:0] par_acc  = '0;
   logic [7:0] val_acc  = '0;
   logic [7:0] chk_acc  = '0;

   frame_type expected_frames[$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_request      = 0;
   int hold_left         = 0;
   int sent_chars        = 0;
   int mismatch_count    = 0;
   int quiet_cycles      = 0;

   ascii_hex_command_frame_parser u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_command    (rsp_command),
      .rsp_param_byte (rsp_param_byte),
      .rsp_value_byte (rsp_value_byte),
      .rsp_parity_rx  (rsp_parity_rx),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic [3:0] digit_value(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return 4'(ch - "0");
      if (ch >= "A" && ch <= "F") return 4'(ch - "A" + 10);
      if (ch >= "a" && ch <= "f") return 4'(ch - "a" + 10);
      return 4'd0;
   endfunction

   function automatic logic [7:0] non_newline_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(255)); while (ch == NEWLINE_CHAR);
      return ch;
   endfunction

   // mixed case digits, with an occasional junk character in a digit slot
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if ($urandom_range(19) == 0) return non_newline_char();
      if (nib < 4'd10) return 8'(8'h30 + nib);
      return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10);
   endfunction

   // Advance the predicted line state by one accepted character.
   task automatic track_char(input logic [7:0] ch);
      logic [7:0] len;
      logic [3:0] nib;
      frame_type  f;
      if (ch == NEWLINE_CHAR) begin
         len = (line_len == COUNT_MAX) ? COUNT_MAX : line_len + 8'd1;
         f.command    = cmd_acc;
         f.param_byte = par_acc;
         f.value_byte = val_acc;
         f.parity_rx  = chk_acc;
         if (len <= HELP_MAX_LEN) begin
            f.status = STATUS_HELP;
         end else if (len < FULL_LEN) begin
            f.status = STATUS_INCOMPLETE;
         end else if ((cmd_acc ^ par_acc ^ val_acc) == chk_acc) begin
            f.status = STATUS_OK;
         end else begin
            f.status = STATUS_PARITY_ERR;
         end
         expected_frames.push_back(f);
         line_len = '0;
         cmd_acc  = '0;
         par_acc  = '0;
         val_acc  = '0;
         chk_acc  = '0;
      end else begin
         nib = digit_value(ch);
         case (line_len)
            POS_CMD_HI: cmd_acc[7:4] = nib;
            POS_CMD_LO: cmd_acc[3:0] = nib;
            POS_PAR_HI: par_acc[7:4] = nib;
            POS_PAR_LO: par_acc[3:0] = nib;
            POS_VAL_HI: val_acc[7:4] = nib;
            POS_VAL_LO: val_acc[3:0] = nib;
            POS_CHK_HI: chk_acc[7:4] = nib;
            POS_CHK_LO: chk_acc[3:0] = nib;
            default: ;
         endcase
         if (line_len != COUNT_MAX) line_len = line_len + 8'd1;
      end
   endtask

   task automatic push_char(input logic [7:0] ch);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_char = ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_char(ch);
      sent_chars++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) note_failure($sformatf("%s expected %02h, got %02h", name, want, got));
   endtask

   // Mostly well-formed lines with random content; some cut short, some pure noise.
   task automatic send_random_line();
      logic [7:0] chars[$];
      logic [7:0] fields[4];
      int         roll;
      int         keep;
      roll = $urandom_range(99);
      if (roll < 85) begin
         fields[0] = 8'($urandom);
         fields[1] = 8'($urandom);
         fields[2] = 8'($urandom);
         fields[3] = ($urandom_range(3) == 0) ? 8'($urandom)
                                              : fields[0] ^ fields[1] ^ fields[2];
         for (int k = 0; k < 4; k++) begin
            chars.push_back(non_newline_char());
            chars.push_back(hex_char(fields[k][7:4]));
            chars.push_back(hex_char(fields[k][3:0]));
         end
         if (roll >= 70) begin
            keep = $urandom_range(11);
            while (chars.size() > keep) void'(chars.pop_back());
         end else if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 6)) chars.push_back(non_newline_char());
         end
      end else begin
         // raw bytes; a stray newline simply splits the line
         repeat ($urandom_range(15)) chars.push_back(8'($urandom_range(255)));
      end
      chars.push_back(NEWLINE_CHAR);
      foreach (chars[k]) push_char(chars[k]);
   endtask

   task automatic test_directed_frames();
      send_text("\n");
      send_text("C\n");
      send_text("C1\n");
      // accepted frame with extreme marker bytes: 12 ^ AB ^ CD = 74
      push_char(8'h00);
      send_text("12");
      push_char(8'hFF);
      send_text("aB");
      push_char(8'h80);
      send_text("cDQ74\n");
      // parity error, with a non-hex character in the value field
      send_text("CFfPA0V9gQ1b\n");
   endtask

   task automatic test_long_lines();
      repeat (300) push_char(non_newline_char());
      push_char(NEWLINE_CHAR);
      send_text("Ca5P0fVe1Q4bxyz\n");
   endtask

   task automatic test_random_lines(input int n_chars);
      int stop_at;
      stop_at = sent_chars + n_chars;
      while (sent_chars < stop_at) send_random_line();
   endtask

   // Output held off while short lines keep coming, so the input side backs up.
   task automatic test_output_hold_off();
      wait_drained();
      hold_request = HOLD_CYCLES;
      repeat (4) send_text("\n");
      send_text("C12P34V56Q70\n");
      send_text("C1\n");
      wait_drained();
   endtask

   // receiver: random stall, or a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_frames
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            note_failure($sformatf("result transaction with nothing expected: %02h %02h %02h %02h %0d",
                                   rsp_command, rsp_param_byte, rsp_value_byte, rsp_parity_rx,
                                   rsp_status));
         end else begin
            want = expected_frames.pop_front();
            check_field("command", want.command, rsp_command);
            check_field("param_byte", want.param_byte, rsp_param_byte);
            check_field("value_byte", want.value_byte, rsp_value_byte);
            check_field("parity_rx", want.parity_rx, rsp_parity_rx);
            check_field("status", {6'd0, want.status}, {6'd0, rsp_status});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_char = 8'h00;
      sender_idle_pct   = 9;
      receiver_idle_pct = 48;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_long_lines();
      test_random_lines(330);
      wait_drained();

      sender_idle_pct   = 48;
      receiver_idle_pct = 9;
      test_output_hold_off();
      test_random_lines(330);
      wait_drained();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_lines(330);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0)
         note_failure($sformatf("%0d frames never arrived", expected_frames.size()));
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
